/* rtl/core/double_hash_table_engine_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the double hash table engine
// Concurrent checks on the clock, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_TABLE_ENGINE_MACROS_SVH
`define DOUBLE_HASH_TABLE_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds on every edge outside reset
`define DHTE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never occurs outside reset
`define DHTE_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define DHTE_ASSERT(lbl, clk, rstn, prop, msg)
`define DHTE_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* rtl/core/dhte_pkg.sv */
// ----------------------------------------------------------------------------
// dhte_pkg
// Shared sizes, codes and types of the double hash table engine.
// ----------------------------------------------------------------------------
package dhte_pkg;

  // Table geometry
  localparam int TABLE_SIZE = 1021;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int SIZE_W     = $clog2(TABLE_SIZE + 1);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int SCALE_W    = 32 + SIZE_W;

  // Field widths
  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;
  localparam int MULT_W     = 32;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int LIVE_W     = 10;
  localparam int SST_W      = 2;
  localparam int WORD_W     = SST_W + KEY_W + VAL_W;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 2;

  // Derived constants
  localparam logic [SIZE_W-1:0] SIZE_C     = SIZE_W'(TABLE_SIZE);
  localparam logic [SIZE_W-1:0] SIZE_M1_C  = SIZE_W'(TABLE_SIZE - 1);
  localparam logic [ADDR_W:0]   SIZE_WIDE  = (ADDR_W + 1)'(TABLE_SIZE);
  localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0]  LOAD_LIMIT = CNT_W'(TABLE_SIZE / 4);

  // Configuration register reset values
  localparam logic [MULT_W-1:0] BASE_MULT_RST = 32'd2654435769;
  localparam logic [MULT_W-1:0] STEP_MULT_RST = 32'd1779033704;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_MULT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MULT = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_EXHAUSTED = 3'd5
  } status_t;

  typedef enum logic [SST_W-1:0] {
    SLOT_EMPTY    = 2'd0,
    SLOT_OCCUPIED = 2'd1,
    SLOT_DELETED  = 2'd2
  } slot_state_t;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_HASH1,
    FSM_HASH2,
    FSM_READ,
    FSM_CHECK
  } fsm_t;

  // Probe start and step from the hash unit
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] step;
  } hash_t;

endpackage

/* rtl/core/dhte_ram.sv */
// ----------------------------------------------------------------------------
// dhte_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dhte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/dhte_hash.sv */
// ----------------------------------------------------------------------------
// dhte_hash
// Probe start and step from a key: multiplicative fractions, then scaling.
// ----------------------------------------------------------------------------
module dhte_hash (
  input  logic                         clk,
  input  logic [dhte_pkg::KEY_W-1:0]   key,
  input  logic [dhte_pkg::MULT_W-1:0]  base_mult,
  input  logic [dhte_pkg::MULT_W-1:0]  step_mult,
  output dhte_pkg::hash_t              hash
);

  logic [dhte_pkg::MULT_W-1:0]  frac_a_r;
  logic [dhte_pkg::MULT_W-1:0]  frac_b_r;
  logic [dhte_pkg::MULT_W-1:0]  frac_a_nxt;
  logic [dhte_pkg::MULT_W-1:0]  frac_b_nxt;
  logic [dhte_pkg::SCALE_W-1:0] scaled_a;
  logic [dhte_pkg::SCALE_W-1:0] scaled_b;

  // Keep the low word of multiplier times key as a 0.32 fraction
  assign frac_a_nxt = base_mult * {1'b0, key};
  assign frac_b_nxt = step_mult * {1'b0, key};

  always_ff @(posedge clk) begin
    frac_a_r <= frac_a_nxt;
    frac_b_r <= frac_b_nxt;
  end

  // Scale by size (start) or size - 1 (step); the integer part is the result
  assign scaled_a = {{dhte_pkg::SIZE_W{1'b0}}, frac_a_r}
                  * {{dhte_pkg::MULT_W{1'b0}}, dhte_pkg::SIZE_C};
  assign scaled_b = {{dhte_pkg::SIZE_W{1'b0}}, frac_b_r}
                  * {{dhte_pkg::MULT_W{1'b0}}, dhte_pkg::SIZE_M1_C};

  assign hash.start = scaled_a[dhte_pkg::MULT_W +: dhte_pkg::ADDR_W];
  assign hash.step  = scaled_b[dhte_pkg::MULT_W +: dhte_pkg::ADDR_W]
                    + dhte_pkg::ADDR_W'(1);

endmodule

/* rtl/core/double_hash_table_engine.sv */
// ----------------------------------------------------------------------------
// double_hash_table_engine
// Open-addressing hash table with double hashing, one result per request.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory once to mark every slot empty,
// one slot per cycle, with in_tready low until the sweep is done;
// configuration writes are taken throughout. A request then passes the
// states HASH1 and HASH2 for the hash multiplies, then READ and CHECK for
// each slot probed (1 to TABLE_SIZE), as the slot memory read is registered.
// The next request is taken in the cycle after a result is loaded. A finished
// result waits in the output register while the next request is accepted and
// hashed; a decided probe holds until that register is free. Kind 3 costs one
// probe and reports not found.
// ----------------------------------------------------------------------------
module double_hash_table_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dhte_pkg::IN_DATA_W-1:0]  in_tdata,   // [30:0] key, [62:31] value
  input  logic [dhte_pkg::KIND_W-1:0]     in_tuser,   // [1:0] kind
  // Result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dhte_pkg::OUT_DATA_W-1:0] out_tdata,  // [31:0] found_value,
                                                      // [41:32] live_count,
                                                      // [42] load_high
  output logic [dhte_pkg::STATUS_W-1:0]   out_tuser,  // [2:0] status
  // Configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dhte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dhte_pkg::MULT_W-1:0]     cfg_data
);

  `include "double_hash_table_engine_macros.svh"

  localparam int KEY_LO = dhte_pkg::SST_W;
  localparam int VAL_LO = dhte_pkg::SST_W + dhte_pkg::KEY_W;

  dhte_pkg::fsm_t                 state_r, state_nxt;
  logic [dhte_pkg::MULT_W-1:0]    base_mult_r;
  logic [dhte_pkg::MULT_W-1:0]    step_mult_r;
  dhte_pkg::kind_t                kind_r;
  logic [dhte_pkg::KIND_W-1:0]    kind_raw_r;
  logic [dhte_pkg::KEY_W-1:0]     key_r;
  logic [dhte_pkg::VAL_W-1:0]     value_r;
  logic [dhte_pkg::ADDR_W-1:0]    h_r, h_nxt;
  logic [dhte_pkg::ADDR_W-1:0]    step_r;
  logic [dhte_pkg::ADDR_W-1:0]    probe_r;
  logic [dhte_pkg::ADDR_W-1:0]    clr_addr_r;
  logic [dhte_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic                           out_valid_r;
  dhte_pkg::status_t              out_status_r;
  logic [dhte_pkg::VAL_W-1:0]     out_value_r;
  logic [dhte_pkg::LIVE_W-1:0]    out_live_r;
  logic                           out_load_r;

  dhte_pkg::hash_t                hash;
  logic [dhte_pkg::WORD_W-1:0]    rd_word;
  logic [dhte_pkg::WORD_W-1:0]    wr_word;
  logic [dhte_pkg::WORD_W-1:0]    ram_wdata;
  logic [dhte_pkg::ADDR_W-1:0]    ram_waddr;
  logic                           ram_we;
  logic [dhte_pkg::ADDR_W:0]      h_sum;

  dhte_pkg::slot_state_t          slot_st;
  logic [dhte_pkg::KEY_W-1:0]     slot_key;
  logic [dhte_pkg::VAL_W-1:0]     slot_val;
  logic                           match;
  logic                           decided;
  logic                           slot_wr;
  logic                           cnt_inc;
  logic                           cnt_dec;
  dhte_pkg::status_t              dec_status;
  logic [dhte_pkg::VAL_W-1:0]     dec_value;
  logic                           out_free;
  logic                           commit;
  logic                           advance;
  logic                           in_fire;

  // Hash unit and slot memory
  dhte_hash u_hash (
    .clk       (clk),
    .key       (key_r),
    .base_mult (base_mult_r),
    .step_mult (step_mult_r),
    .hash      (hash)
  );

  dhte_ram #(
    .WIDTH (dhte_pkg::WORD_W),
    .DEPTH (dhte_pkg::TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (h_r),
    .rdata (rd_word)
  );

  // Unpack the slot that was read
  assign slot_st  = dhte_pkg::slot_state_t'(rd_word[dhte_pkg::SST_W-1:0]);
  assign slot_key = rd_word[KEY_LO +: dhte_pkg::KEY_W];
  assign slot_val = rd_word[VAL_LO +: dhte_pkg::VAL_W];
  assign match    = (slot_st == dhte_pkg::SLOT_OCCUPIED) && (slot_key == key_r);

  // Decide the current probe
  always_comb begin
    decided    = 1'b0;
    slot_wr    = 1'b0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    dec_status = dhte_pkg::ST_EXHAUSTED;
    dec_value  = '0;
    wr_word    = rd_word;
    unique case (kind_raw_r)
      dhte_pkg::KIND_INSERT: begin
        if (slot_st != dhte_pkg::SLOT_OCCUPIED) begin
          decided    = 1'b1;
          slot_wr    = 1'b1;
          cnt_inc    = 1'b1;
          dec_status = dhte_pkg::ST_INSERTED;
          wr_word    = {value_r, key_r, dhte_pkg::SLOT_OCCUPIED};
        end else if (match) begin
          decided    = 1'b1;
          dec_status = dhte_pkg::ST_DUPLICATE;
        end
      end
      dhte_pkg::KIND_FIND: begin
        if (slot_st == dhte_pkg::SLOT_EMPTY) begin
          decided    = 1'b1;
          dec_status = dhte_pkg::ST_NOT_FOUND;
        end else if (match) begin
          decided    = 1'b1;
          dec_status = dhte_pkg::ST_FOUND;
          dec_value  = slot_val;
        end
      end
      dhte_pkg::KIND_REMOVE: begin
        if (slot_st == dhte_pkg::SLOT_EMPTY) begin
          decided    = 1'b1;
          dec_status = dhte_pkg::ST_NOT_FOUND;
        end else if (match) begin
          decided    = 1'b1;
          slot_wr    = 1'b1;
          cnt_dec    = 1'b1;
          dec_status = dhte_pkg::ST_REMOVED;
          wr_word    = {slot_val, slot_key, dhte_pkg::SLOT_DELETED};
        end
      end
      default: begin
        decided    = 1'b1;
        dec_status = dhte_pkg::ST_NOT_FOUND;
      end
    endcase
    // Last probe without a decision ends the request
    if (!decided && (probe_r == dhte_pkg::ADDR_LAST)) begin
      decided    = 1'b1;
      dec_status = dhte_pkg::ST_EXHAUSTED;
    end
  end

  // Probe control
  assign out_free  = !out_valid_r || out_tready;
  assign commit    = (state_r == dhte_pkg::FSM_CHECK) && decided && out_free;
  assign advance   = (state_r == dhte_pkg::FSM_CHECK) && !decided;
  assign in_tready = (state_r == dhte_pkg::FSM_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Step the probe address modulo the table size
  assign h_sum = {1'b0, h_r} + {1'b0, step_r};
  always_comb begin
    if (h_sum >= dhte_pkg::SIZE_WIDE) begin
      h_nxt = dhte_pkg::ADDR_W'(h_sum - dhte_pkg::SIZE_WIDE);
    end else begin
      h_nxt = h_sum[dhte_pkg::ADDR_W-1:0];
    end
  end

  // Select the memory write: clearing sweep or committed slot update
  always_comb begin
    if (state_r == dhte_pkg::FSM_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = commit && slot_wr;
      ram_waddr = h_r;
      ram_wdata = wr_word;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (commit && cnt_inc) begin
      count_nxt = count_r + dhte_pkg::CNT_W'(1);
    end else if (commit && cnt_dec) begin
      count_nxt = count_r - dhte_pkg::CNT_W'(1);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dhte_pkg::FSM_CLEAR: begin
        if (clr_addr_r == dhte_pkg::ADDR_LAST) state_nxt = dhte_pkg::FSM_IDLE;
      end
      dhte_pkg::FSM_IDLE: begin
        if (in_fire) state_nxt = dhte_pkg::FSM_HASH1;
      end
      dhte_pkg::FSM_HASH1: state_nxt = dhte_pkg::FSM_HASH2;
      dhte_pkg::FSM_HASH2: state_nxt = dhte_pkg::FSM_READ;
      dhte_pkg::FSM_READ:  state_nxt = dhte_pkg::FSM_CHECK;
      dhte_pkg::FSM_CHECK: begin
        if (commit) begin
          state_nxt = dhte_pkg::FSM_IDLE;
        end else if (advance) begin
          state_nxt = dhte_pkg::FSM_READ;
        end
      end
      default: state_nxt = dhte_pkg::FSM_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dhte_pkg::FSM_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      base_mult_r <= dhte_pkg::BASE_MULT_RST;
      step_mult_r <= dhte_pkg::STEP_MULT_RST;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == dhte_pkg::FSM_CLEAR) begin
        clr_addr_r <= clr_addr_r + dhte_pkg::ADDR_W'(1);
      end
      // Hold a result until taken, load a new one on commit
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dhte_pkg::CFG_BASE_MULT) base_mult_r <= cfg_data;
        if (cfg_index == dhte_pkg::CFG_STEP_MULT) step_mult_r <= cfg_data;
      end
    end
  end

  // Request and probe payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_raw_r <= in_tuser;
      key_r      <= in_tdata[dhte_pkg::KEY_W-1:0];
      value_r    <= in_tdata[dhte_pkg::KEY_W +: dhte_pkg::VAL_W];
    end
    if (state_r == dhte_pkg::FSM_HASH2) begin
      h_r     <= hash.start;
      step_r  <= hash.step;
      probe_r <= '0;
    end else if (advance) begin
      h_r     <= h_nxt;
      probe_r <= probe_r + dhte_pkg::ADDR_W'(1);
    end
    if (commit) begin
      out_status_r <= dec_status;
      out_value_r  <= dec_value;
      out_live_r   <= dhte_pkg::LIVE_W'(count_nxt);
      out_load_r   <= (count_nxt > dhte_pkg::LOAD_LIMIT);
    end
  end

  assign kind_r = dhte_pkg::kind_t'(kind_raw_r);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(dhte_pkg::OUT_DATA_W - dhte_pkg::VAL_W - dhte_pkg::LIVE_W - 1){1'b0}},
                       out_load_r, out_live_r, out_value_r};

  // Checks on the probe datapath and the live count
  `DHTE_NEVER(a_waddr_range, clk, rst_n,
              ram_we && (ram_waddr > dhte_pkg::ADDR_LAST),
              "slot write out of range")
  `DHTE_NEVER(a_probe_range, clk, rst_n,
              (state_r == dhte_pkg::FSM_CHECK) && (h_r > dhte_pkg::ADDR_LAST),
              "probe address out of range")
  `DHTE_NEVER(a_count_range, clk, rst_n,
              count_r > dhte_pkg::CNT_W'(dhte_pkg::TABLE_SIZE),
              "live count above table size")
  `DHTE_ASSERT(a_count_result, clk, rst_n,
               (count_r != $past(count_r)) |->
                 (out_valid_r && (kind_r != dhte_pkg::KIND_FIND)),
               "live count moved without a result")

endmodule
